/* rtl/core/wcss_pkg.sv */
// ----------------------------------------------------------------------------
// wcss_pkg
// Shared types and constants for the windowed constrained subsequence sum.
// ----------------------------------------------------------------------------
package wcss_pkg;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 48;
  localparam int unsigned WinW    = 7;

  // register port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 1;

  // register indexes
  localparam logic [RegIdxW-1:0] RegWindow = 1'b0;

  // accumulator bounds
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // input transfer payload
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } in_t;

  // output transfer payload
  typedef struct packed {
    logic signed [AccW-1:0] ending_here;
    logic signed [AccW-1:0] best_so_far;
    logic                   done_res;
  } out_t;

endpackage

/* rtl/core/wcss_apb_regs.sv */
// ----------------------------------------------------------------------------
// wcss_apb_regs
// Register port: holds the window register and hands out its clamped value.
// ----------------------------------------------------------------------------
module wcss_apb_regs #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned CntW       = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wcss_pkg::ApbAddrW-1:0] paddr,
  input  logic [wcss_pkg::ApbDataW-1:0] pwdata,
  output logic [wcss_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output logic [CntW-1:0]               win_len_o
);
  import wcss_pkg::*;

  logic [WinW-1:0]    window_q, window_d;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;
  logic [31:0]        win_ext;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  // register write decode
  always_comb begin
    window_d = window_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegWindow: window_d = pwdata[WinW-1:0];
        default:   window_d = window_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinW'(1);
    end else begin
      window_q <= window_d;
    end
  end

  // read data
  always_comb begin
    unique case (reg_idx)
      RegWindow: prdata = {{(ApbDataW-WinW){1'b0}}, window_q};
      default:   prdata = '0;
    endcase
  end

  // zero counts as one, anything above the cell count as the cell count
  assign win_ext = {{(32-WinW){1'b0}}, window_q};
  always_comb begin
    if (window_q == '0) begin
      win_len_o = CntW'(1);
    end else if (win_ext > 32'(WINDOW_MAX)) begin
      win_len_o = CntW'(WINDOW_MAX);
    end else begin
      win_len_o = CntW'(win_ext);
    end
  end

endmodule

/* rtl/core/window_constrained_subsequence_sum_top.sv */
// ----------------------------------------------------------------------------
// window_constrained_subsequence_sum_top
// Best windowed subsequence sum ending at each sample, with running maximum.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   in       | input     | in_valid_i / in_stall_o | sample, last
//   out      | output    | out_valid_o/out_stall_i | ending_here, best_so_far,
//            |           |                         | done_res
//   config   | input     | APB psel/penable/pready | window register
//
// Each item scans k = min(window, sums held in the sequence) stored sums
// through the single read port of the sum memory, one entry a cycle.
// With no sums held yet (first sample of a sequence) the scan is skipped.
// After reset the memory holds nothing valid; a fill count tracks entries.
// A stalled output holds the result register; the next item is still taken
// and waits only at its final step for the register to free up.
// ----------------------------------------------------------------------------
module window_constrained_subsequence_sum_top #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wcss_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wcss_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wcss_pkg::ApbAddrW-1:0] paddr,
  input  logic [wcss_pkg::ApbDataW-1:0] pwdata,
  output logic [wcss_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import wcss_pkg::*;

  localparam int unsigned AddrW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW_MAX + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WINDOW_MAX - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(WINDOW_MAX);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StWait = 4'b0100,
    StCalc = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] win_len;

  // sum memory and its read path
  logic signed [AccW-1:0] sum_mem [WINDOW_MAX];
  logic signed [AccW-1:0] rdata_q;
  logic                   rpend_q;

  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  scan_len;

  logic signed [AccW-1:0]    prev_q, prev_d;
  logic signed [AccW-1:0]    best_q, best_d;
  logic signed [SampleW-1:0] sample_q;
  logic                      last_q;

  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  logic                   in_acc;
  logic                   calc_go;
  logic signed [AccW:0]   sum_ext;
  logic signed [AccW-1:0] cur;
  logic signed [AccW-1:0] best_new;

  wcss_apb_regs #(
    .WINDOW_MAX (WINDOW_MAX),
    .CntW       (CntW)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .win_len_o (win_len)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign calc_go     = (state_q == StCalc) & ~(out_valid_q & out_stall_i);

  // entries to scan: the window, capped by what the sequence holds
  assign scan_len = (win_len < fill_q) ? win_len : fill_q;

  // saturating add; the held maximum is never negative
  assign sum_ext  = {prev_q[AccW-1], prev_q} +
                    (AccW+1)'(sample_q);
  assign cur      = (sum_ext > $signed({1'b0, AccMax})) ? AccMax : sum_ext[AccW-1:0];
  assign best_new = (cur > best_q) ? cur : best_q;

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    raddr_d     = raddr_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    prev_d      = prev_q;
    best_d      = best_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;

    // fold in read data as it returns
    if (rpend_q && (rdata_q > prev_q)) begin
      prev_d = rdata_q;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          prev_d  = '0;
          rem_d   = scan_len;
          raddr_d = (wptr_q == '0) ? LastAddr : wptr_q - AddrW'(1);
          state_d = (scan_len == '0) ? StCalc : StRead;
        end
      end
      StRead: begin
        raddr_d = (raddr_q == '0) ? LastAddr : raddr_q - AddrW'(1);
        rem_d   = rem_q - CntW'(1);
        if (rem_q == CntW'(1)) begin
          state_d = StWait;
        end
      end
      StWait: begin
        state_d = StCalc;
      end
      StCalc: begin
        if (calc_go) begin
          out_valid_d       = 1'b1;
          out_d.ending_here = cur;
          out_d.best_so_far = best_new;
          out_d.done_res    = last_q;
          if (last_q) begin
            fill_d = '0;
            best_d = AccMin;
          end else begin
            best_d = best_new;
            wptr_d = (wptr_q == LastAddr) ? '0 : wptr_q + AddrW'(1);
            if (fill_q != FullCnt) begin
              fill_d = fill_q + CntW'(1);
            end
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wptr_q      <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      best_q      <= AccMin;
      out_valid_q <= 1'b0;
      rpend_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
      rpend_q     <= (state_q == StRead);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    prev_q  <= prev_d;
    out_q   <= out_d;
    if (in_acc) begin
      sample_q <= in_data_i.sample;
      last_q   <= in_data_i.last;
    end
  end

  // sum memory: one read, one write port
  always_ff @(posedge clk_i) begin
    if (calc_go && !last_q) begin
      sum_mem[wptr_q] <= cur;
    end
    rdata_q <= sum_mem[raddr_q];
  end

endmodule
